// ===== rtl/mtcqf_pkg.sv =====
//------------------------------------------------------------------------------
// mtcqf_pkg
// Shared types, constants and the rate-to-period table of the MIDI time code
// quarter-frame generator.
//------------------------------------------------------------------------------
`default_nettype none

package mtcqf_pkg;

	localparam int unsigned TICK_HZ = 1000000;

	localparam int SEC_W    = 20;
	localparam int PERIOD_W = 16;
	localparam int PIECE_W  = 3;

	localparam logic [SEC_W-1:0] SEC_LAST = SEC_W'(TICK_HZ - 1);

	localparam logic [PERIOD_W-1:0] PERIOD_24 = PERIOD_W'(TICK_HZ / 24 / 4);
	localparam logic [PERIOD_W-1:0] PERIOD_25 = PERIOD_W'(TICK_HZ / 25 / 4);
	localparam logic [PERIOD_W-1:0] PERIOD_30 = PERIOD_W'(TICK_HZ / 30 / 4);

	localparam logic [7:0] STATUS_QF  = 8'hF1;
	localparam logic [7:0] RATE_MIN   = 8'd24;
	localparam logic [7:0] RATE_MAX   = 8'd30;
	localparam logic [7:0] RATE_RESET = 8'd1;

	typedef enum logic {
		OP_TIMECODE = 1'b0,
		OP_TICK     = 1'b1
	} op_t;

	typedef enum logic {
		KIND_QUARTER = 1'b0,
		KIND_FULL    = 1'b1
	} kind_t;

	typedef enum logic [7:0] {
		TYPE_24    = 8'd0,
		TYPE_25    = 8'd1,
		TYPE_30DF  = 8'd2,
		TYPE_30    = 8'd3
	} rate_type_t;

	typedef struct packed {
		logic       operation;
		logic [4:0] tc_hours;
		logic [5:0] tc_minutes;
		logic [5:0] tc_seconds;
		logic [4:0] tc_frames;
		logic [7:0] tc_rate_type;
	} item_t;

	typedef struct packed {
		logic       message_kind;
		logic [7:0] status_byte;
		logic [7:0] data_byte;
		logic [4:0] frame_hours;
		logic [5:0] frame_minutes;
		logic [5:0] frame_seconds;
		logic [4:0] frame_frames;
		logic [7:0] frame_rate;
	} result_t;

	function automatic logic [PERIOD_W-1:0] period_for(input logic [7:0] rate_type);
		logic [PERIOD_W-1:0] p;
		case (rate_type)
			TYPE_24:   p = PERIOD_24;
			TYPE_25:   p = PERIOD_25;
			TYPE_30DF: p = PERIOD_30;
			TYPE_30:   p = PERIOD_30;
			default:   p = '0;
		endcase
		return p;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/mtcqf_core.sv =====
//------------------------------------------------------------------------------
// mtcqf_core
// Timecode store, update-rate measurement, quarter-frame timer and message
// formation. One request is handled per cycle while the output buffer has room;
// the result is written to the output buffer in the same cycle.
//------------------------------------------------------------------------------
`default_nettype none

module mtcqf_core (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   cfg_we,
	input  wire                   cfg_data,
	input  wire                   item_valid,
	input  mtcqf_pkg::item_t      item,
	output logic                  res_valid,
	output mtcqf_pkg::result_t    res
);
	import mtcqf_pkg::*;

	logic                midi_enable_q;
	logic [4:0]          hours_q;
	logic [5:0]          minutes_q;
	logic [5:0]          seconds_q;
	logic [4:0]          frames_q;
	logic [7:0]          rate_q;
	logic [7:0]          last_type_q;
	logic                type_known_q;
	logic [7:0]          win_upd_q;
	logic [7:0]          meas_rate_q;
	logic [SEC_W-1:0]    sec_tmr_q;
	logic [PERIOD_W-1:0] period_q;
	logic [PERIOD_W-1:0] qtr_tmr_q;
	logic                pending_q;
	logic [PIECE_W-1:0]  piece_q;

	logic                is_tc;
	logic                is_tick;
	logic                type_change;
	logic                full_req;
	logic                sec_wrap;
	logic [7:0]          meas_rate_n;
	logic [PERIOD_W-1:0] qtr_inc;
	logic                qtr_fire;
	logic                pend_now;
	logic                rate_ok;
	logic                emit_qf;
	logic [3:0]          nibble;

	assign is_tc       = item_valid && (item.operation == OP_TIMECODE);
	assign is_tick     = item_valid && (item.operation == OP_TICK);
	assign type_change = !type_known_q || (last_type_q != item.tc_rate_type);
	assign full_req    = is_tc && type_change && midi_enable_q;

	assign sec_wrap    = (sec_tmr_q == SEC_LAST);
	assign meas_rate_n = sec_wrap ? win_upd_q : meas_rate_q;
	assign qtr_inc     = qtr_tmr_q + PERIOD_W'(1);
	assign qtr_fire    = (period_q != '0) && (qtr_inc >= period_q);
	assign pend_now    = pending_q || qtr_fire;
	assign rate_ok     = (meas_rate_n >= RATE_MIN) && (meas_rate_n <= RATE_MAX);
	assign emit_qf     = is_tick && midi_enable_q && rate_ok && pend_now;

	always_comb begin
		case (piece_q)
			3'd0:    nibble = frames_q[3:0];
			3'd1:    nibble = {3'b000, frames_q[4]};
			3'd2:    nibble = seconds_q[3:0];
			3'd3:    nibble = {2'b00, seconds_q[5:4]};
			3'd4:    nibble = minutes_q[3:0];
			3'd5:    nibble = {2'b00, minutes_q[5:4]};
			3'd6:    nibble = hours_q[3:0];
			default: nibble = {1'b0, rate_q[1:0], hours_q[4]};
		endcase
	end

	always_comb begin
		res_valid = full_req || emit_qf;
		res       = '0;
		if (full_req) begin
			res.message_kind  = KIND_FULL;
			res.frame_hours   = item.tc_hours;
			res.frame_minutes = item.tc_minutes;
			res.frame_seconds = item.tc_seconds;
			res.frame_frames  = item.tc_frames;
			res.frame_rate    = item.tc_rate_type;
		end else begin
			res.message_kind = KIND_QUARTER;
			res.status_byte  = STATUS_QF;
			res.data_byte    = {1'b0, piece_q, nibble};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			midi_enable_q <= 1'b0;
			hours_q       <= '0;
			minutes_q     <= '0;
			seconds_q     <= '0;
			frames_q      <= '0;
			rate_q        <= RATE_RESET;
			last_type_q   <= '0;
			type_known_q  <= 1'b0;
			win_upd_q     <= '0;
			meas_rate_q   <= '0;
			sec_tmr_q     <= '0;
			period_q      <= '0;
			qtr_tmr_q     <= '0;
			pending_q     <= 1'b0;
			piece_q       <= '0;
		end else begin
			if (cfg_we) begin
				midi_enable_q <= cfg_data;
			end
			if (is_tc) begin
				hours_q   <= item.tc_hours;
				minutes_q <= item.tc_minutes;
				seconds_q <= item.tc_seconds;
				frames_q  <= item.tc_frames;
				rate_q    <= item.tc_rate_type;
				if (win_upd_q != 8'hFF) begin
					win_upd_q <= win_upd_q + 8'd1;
				end
				if (type_change) begin
					last_type_q  <= item.tc_rate_type;
					type_known_q <= 1'b1;
				end
				if (full_req) begin
					piece_q   <= '0;
					period_q  <= period_for(item.tc_rate_type);
					qtr_tmr_q <= '0;
				end
			end
			if (is_tick) begin
				meas_rate_q <= meas_rate_n;
				if (sec_wrap) begin
					sec_tmr_q <= '0;
					win_upd_q <= '0;
				end else begin
					sec_tmr_q <= sec_tmr_q + SEC_W'(1);
				end
				if (period_q != '0) begin
					qtr_tmr_q <= qtr_fire ? '0 : qtr_inc;
				end
				pending_q <= pend_now && !emit_qf;
				if (emit_qf) begin
					piece_q <= piece_q + PIECE_W'(1);
				end
			end
		end
	end

	a_qtr_tmr_below_period: assert property (@(posedge clk) disable iff (!arst_n)
		(period_q != '0) |-> (qtr_tmr_q < period_q))
		else $error("quarter timer reached its period");

	a_sec_tmr_range: assert property (@(posedge clk) disable iff (!arst_n)
		sec_tmr_q <= SEC_LAST)
		else $error("second timer out of range");

	a_emit_clears_pending: assert property (@(posedge clk) disable iff (!arst_n)
		emit_qf |=> !pending_q)
		else $error("pending flag kept after quarter frame");

	a_piece_restart: assert property (@(posedge clk) disable iff (!arst_n)
		full_req |=> (piece_q == '0) && (qtr_tmr_q == '0))
		else $error("sequence not restarted on full-frame request");

endmodule

`default_nettype wire

// ===== rtl/mtcqf_out_buf.sv =====
//------------------------------------------------------------------------------
// mtcqf_out_buf
// Two-entry result buffer between the core and the output channel, so that
// requests keep flowing while the receiver stalls, until both entries are full.
//------------------------------------------------------------------------------
`default_nettype none

module mtcqf_out_buf (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   push,
	input  mtcqf_pkg::result_t    push_data,
	output logic                  can_push,
	output logic                  out_valid,
	input  wire                   out_ready,
	output mtcqf_pkg::result_t    out_data
);
	import mtcqf_pkg::*;

	result_t    slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       pop;

	assign can_push  = (count_q != 2'd2);
	assign out_valid = (count_q != 2'd0);
	assign out_data  = slot_q[rd_ptr_q];
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 2'd2) |-> !push)
		else $error("result pushed into full buffer");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("buffer count out of range");

endmodule

`default_nettype wire

// ===== rtl/midi_timecode_quarter_frame_generator_unit.sv =====
//------------------------------------------------------------------------------
// midi_timecode_quarter_frame_generator_unit
// MIDI time code generator: stores received timecode, measures the update
// rate and emits full-frame requests and 0xF1 quarter-frame messages.
//------------------------------------------------------------------------------
// Usage:
//   cfg channel: cfg_valid/cfg_ready with midi_enable; always ready, write
//   only while the block is idle.
//   in channel: in_valid/in_ready; each request is a timecode update
//   (operation 0) or one timebase tick (operation 1).
//   out channel: out_valid/out_ready; at most one result per request, either a
//   full-frame request or a quarter-frame message.
//   Throughput: one request per cycle while in_ready is high. With the buffer
//   empty, a result is on the output the cycle after its request is accepted.
//   The core updates all state in the accept cycle; a two-entry result buffer
//   decouples the output, so in_ready only falls when both entries hold
//   results the receiver has not taken.
//   Reset clears all state (stored rate type 25 fps, quarter period zero so no
//   quarter frames run) and empties the result buffer.
//------------------------------------------------------------------------------
`default_nettype none

module midi_timecode_quarter_frame_generator_unit (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        cfg_valid,
	output logic       cfg_ready,
	input  wire        midi_enable,
	input  wire        in_valid,
	output logic       in_ready,
	input  wire        operation,
	input  wire  [4:0] tc_hours,
	input  wire  [5:0] tc_minutes,
	input  wire  [5:0] tc_seconds,
	input  wire  [4:0] tc_frames,
	input  wire  [7:0] tc_rate_type,
	output logic       out_valid,
	input  wire        out_ready,
	output logic       message_kind,
	output logic [7:0] status_byte,
	output logic [7:0] data_byte,
	output logic [4:0] frame_hours,
	output logic [5:0] frame_minutes,
	output logic [5:0] frame_seconds,
	output logic [4:0] frame_frames,
	output logic [7:0] frame_rate
);
	import mtcqf_pkg::*;

	item_t   item;
	result_t res;
	result_t out_data;
	logic    res_valid;
	logic    accept;

	assign cfg_ready = 1'b1;
	assign accept    = in_valid && in_ready;

	assign item.operation    = operation;
	assign item.tc_hours     = tc_hours;
	assign item.tc_minutes   = tc_minutes;
	assign item.tc_seconds   = tc_seconds;
	assign item.tc_frames    = tc_frames;
	assign item.tc_rate_type = tc_rate_type;

	mtcqf_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_valid && cfg_ready),
		.cfg_data   (midi_enable),
		.item_valid (accept),
		.item       (item),
		.res_valid  (res_valid),
		.res        (res)
	);

	mtcqf_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.can_push  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	assign message_kind  = out_data.message_kind;
	assign status_byte   = out_data.status_byte;
	assign data_byte     = out_data.data_byte;
	assign frame_hours   = out_data.frame_hours;
	assign frame_minutes = out_data.frame_minutes;
	assign frame_seconds = out_data.frame_seconds;
	assign frame_frames  = out_data.frame_frames;
	assign frame_rate    = out_data.frame_rate;

endmodule

`default_nettype wire
